/* design/s1cp_pkg.sv */
// Shared constants and elaboration-time helpers for the S1 connection probability block.
`timescale 1ns / 1ps

package s1cp_pkg;

   // Logarithm format: integer part above a 16-bit fraction.
   localparam int LOG_FRAC  = 16;
   localparam int LOG_W     = 22;
   // Latency of the logarithm unit: leading-one search, normalize, one squaring per bit.
   localparam int LOG_LAT   = LOG_FRAC + 2;
   // Number of fraction bits handled by the exp2 stages.
   localparam int EXP_STEPS = 16;
   // The Q8.24 mu and the Q16.16 degrees leave 24 fraction bits to add back in the log domain.
   localparam int LOG_OFFSET = 24 * 65536;
   // One in Q2.30.
   localparam logic [31:0] Q30_ONE = 32'h4000_0000;

   // Truncated integer square root, used only on constants.
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bits;
      rem  = x;
      res  = '0;
      bits = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bits) begin
            rem = rem - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      return res;
   endfunction

   // Coefficient 2^(2^-k) in Q2.30, each one the square root of the one before.
   function automatic logic [31:0] exp2_coef(input int k);
      logic [63:0] c;
      c = 64'h8000_0000;
      for (int i = 1; i <= EXP_STEPS; i++) begin
         if (i <= k) begin
            c = isqrt64(c << 30);
         end
      end
      return c[31:0];
   endfunction

endpackage

/* design/s1cp_log2.sv */
// Pipelined fixed-point log2 unit with a 16-bit fraction from repeated squaring.
`timescale 1ns / 1ps

module s1cp_log2 import s1cp_pkg::*; #(
   parameter int XW = 32
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [XW-1:0]    x,
   output logic [LOG_W-1:0] log_value
);

   localparam int EW = $clog2(XW);

   logic [EW-1:0]    lead_in;
   logic [EW-1:0]    lead_ff;
   logic [XW-1:0]    x_ff;
   logic [XW+30:0]   ext;
   logic [31:0]      mant_in;
   logic [31:0]      mant_ff [0:LOG_FRAC];
   logic [EW-1:0]    exp_ff  [0:LOG_FRAC];
   logic [LOG_FRAC-1:0] frac_ff [0:LOG_FRAC];

   // Index of the top set bit; zero input gives zero.
   always_comb begin
      lead_in = '0;
      for (int i = 0; i < XW; i++) begin
         if (x[i]) begin
            lead_in = EW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x;
         lead_ff <= lead_in;
      end
   end

   // Normalize so the top set bit lands on bit 31 (Q1.31 mantissa).
   assign ext     = {x_ff, 31'b0};
   assign mant_in = 32'(ext >> lead_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         mant_ff[0] <= mant_in;
         exp_ff[0]  <= lead_ff;
         frac_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] sh;
      assign sq = 64'(mant_ff[k-1]) * 64'(mant_ff[k-1]);
      assign sh = sq[63:31];
      always_ff @(posedge clock) begin
         if (enable) begin
            mant_ff[k] <= sh[32] ? sh[32:1] : sh[31:0];
            exp_ff[k]  <= exp_ff[k-1];
            frac_ff[k] <= {frac_ff[k-1][LOG_FRAC-2:0], sh[32]};
         end
      end
   end

   assign log_value = LOG_W'({exp_ff[LOG_FRAC], frac_ff[LOG_FRAC]});

endmodule

/* design/s1cp_recip.sv */
// Pipelined restoring divider giving round(2^(PB+30) / den), one quotient bit per stage.
`timescale 1ns / 1ps

module s1cp_recip #(
   parameter int PB = 16
) (
   input  logic           clock,
   input  logic           enable,
   input  logic [PB+32:0] den,
   output logic [PB:0]    quo
);

   localparam int DW = PB + 33;
   localparam int QW = PB + 1;

   logic [DW-1:0] num_in;
   logic [DW-1:0] rem_ff    [0:QW];
   logic [DW-1:0] den_ff    [0:QW];
   logic [QW-1:0] num_lo_ff [0:QW];
   logic [QW-1:0] quo_ff    [0:QW];

   // Adding half the divisor to the dividend rounds half up.
   assign num_in = DW'({1'b1, (PB + 30)'(0)}) + (den >> 1);

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]    <= num_in >> QW;
         den_ff[0]    <= den;
         num_lo_ff[0] <= num_in[QW-1:0];
         quo_ff[0]    <= '0;
      end
   end

   for (genvar i = 1; i <= QW; i++) begin : g_div
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;
      assign trial = {rem_ff[i-1], num_lo_ff[i-1][QW-i]};
      assign diff  = trial - {1'b0, den_ff[i-1]};
      assign ge    = trial >= {1'b0, den_ff[i-1]};
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]    <= ge ? diff[DW-1:0] : trial[DW-1:0];
            den_ff[i]    <= den_ff[i-1];
            num_lo_ff[i] <= num_lo_ff[i-1];
            quo_ff[i]    <= {quo_ff[i-1][QW-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[QW];

endmodule

/* design/s1_connection_probability.sv */
// Top level of the S1 connection probability pipeline.
`timescale 1ns / 1ps
//
//   Channel | Direction | Handshake               | Beat contents
//   --------+-----------+-------------------------+------------------------------------------
//   req_    | in        | req_valid / req_ready   | two angles, two hidden degrees
//   rsp_    | out       | rsp_valid / rsp_ready   | link probability, Q1.PROB_FRAC_BITS
//   csr_    | in        | csr_write_enable        | register index and write data
//
// One beat enters per cycle while the skid entry is free, and its result passes through
// 2 gap and distance stages, 18 log2 stages, the sum and beta product, 17 exp2 stages, the
// denominator, the divider stages and the output register.
// Reset is synchronous, clears the valid bits of the pipeline and of the output buffers, and
// loads the register defaults. The whole pipeline advances together; an output register plus
// one skid entry let it keep accepting beats while a result waits, and it holds only once the
// skid entry is full.

module s1_connection_probability import s1cp_pkg::*; #(
   parameter int PROB_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [31:0]               req_angle_first,
   input  logic [31:0]               req_angle_second,
   input  logic [31:0]               req_degree_first,
   input  logic [31:0]               req_degree_second,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PROB_FRAC_BITS:0]   rsp_link_probability,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_write_data
);

   localparam int PB  = PROB_FRAC_BITS;
   localparam int QW  = PB + 1;
   localparam int DW  = PB + 33;
   localparam int IPW = $clog2(PB + 2);
   localparam int LW  = 25;
   localparam int PW  = 42;
   localparam int SW  = PW - 8;

   // Register positions of the pipeline, counted from the input register.
   localparam int P_DIST = 2;
   localparam int P_LOG  = P_DIST + LOG_LAT;
   localparam int P_SUM  = P_LOG + 1;
   localparam int P_MUL  = P_SUM + 1;
   localparam int P_SCL  = P_MUL + 1;
   localparam int P_DEN  = P_SCL + EXP_STEPS + 1;
   localparam int P_END  = P_DEN + QW + 1;
   localparam int FA_N   = P_END - P_DIST + 1;
   localparam int FB_N   = P_END - P_SCL + 1;

   localparam logic [1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [1:0] CSR_BETA_VALUE = 2'd1;
   localparam logic [1:0] CSR_MU_VALUE   = 2'd2;

   localparam logic [PB:0] PROB_ONE = {1'b1, PB'(0)};

   typedef struct packed {
      logic dist_zero;
      logic prod_zero;
   } early_flags_type;

   typedef struct packed {
      logic neg;
      logic big;
   } late_flags_type;

   // Configuration registers.
   logic [20:0] node_count_ff;
   logic [15:0] beta_ff;
   logic [31:0] mu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 21'd1024;
         beta_ff       <= 16'd512;
         mu_ff         <= 32'd4194304;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_NODE_COUNT: node_count_ff <= csr_write_data[20:0];
            CSR_BETA_VALUE: beta_ff       <= csr_write_data[15:0];
            CSR_MU_VALUE:   mu_ff         <= csr_write_data;
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the skid entry is free.
   logic en;
   logic [P_END:1] vld_ff;
   logic skid_valid_ff;
   logic out_valid_ff;

   assign en        = !skid_valid_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[P_END-1:1], req_valid};
      end
   end

   // Input stage: circular gap, the shorter way around the turn.
   logic [31:0] diff;
   logic [31:0] gap_in;
   logic [31:0] gap_ff;
   logic [31:0] k1_ff;
   logic [31:0] k2_ff;

   assign diff   = req_angle_first - req_angle_second;
   assign gap_in = (diff > 32'h8000_0000) ? (32'd0 - diff) : diff;

   always_ff @(posedge clock) begin
      if (en) begin
         gap_ff <= gap_in;
         k1_ff  <= req_degree_first;
         k2_ff  <= req_degree_second;
      end
   end

   // Distance stage: d = N * gap, with the special-case flags.
   logic [52:0]     dist_ff;
   logic [31:0]     k1b_ff;
   logic [31:0]     k2b_ff;
   early_flags_type fa_in;
   early_flags_type fa_ff [0:FA_N-1];

   assign fa_in.dist_zero = (node_count_ff == '0) || (gap_ff == '0);
   assign fa_in.prod_zero = (mu_ff == '0) || (k1_ff == '0) || (k2_ff == '0);

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff  <= 53'(node_count_ff) * 53'(gap_ff);
         k1b_ff   <= k1_ff;
         k2b_ff   <= k2_ff;
         fa_ff[0] <= fa_in;
         for (int i = 1; i < FA_N; i++) begin
            fa_ff[i] <= fa_ff[i-1];
         end
      end
   end

   // Four logarithms in parallel lanes.
   logic [LOG_W-1:0] log_dist;
   logic [LOG_W-1:0] log_mu;
   logic [LOG_W-1:0] log_k1;
   logic [LOG_W-1:0] log_k2;

   s1cp_log2 #(.XW(53)) u_log_dist (
      .clock(clock), .enable(en), .x(dist_ff), .log_value(log_dist)
   );
   s1cp_log2 #(.XW(32)) u_log_mu (
      .clock(clock), .enable(en), .x(mu_ff), .log_value(log_mu)
   );
   s1cp_log2 #(.XW(32)) u_log_k1 (
      .clock(clock), .enable(en), .x(k1b_ff), .log_value(log_k1)
   );
   s1cp_log2 #(.XW(32)) u_log_k2 (
      .clock(clock), .enable(en), .x(k2b_ff), .log_value(log_k2)
   );

   // Log of the ratio, then scaled by beta.
   logic signed [LW-1:0] sum_ff;
   logic signed [PW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff  <= LW'({3'b0, log_dist}) - LW'({3'b0, log_mu}) - LW'({3'b0, log_k1})
                    - LW'({3'b0, log_k2}) + LW'(LOG_OFFSET);
         prod_ff <= $signed({1'b0, beta_ff}) * sum_ff;
      end
   end

   // Exponent split: negative products round toward larger magnitude, then the integer
   // part selects the final shift and the fraction drives the exp2 stages.
   logic [PW-1:0]  prod_u;
   logic [PW-1:0]  mag;
   logic           prod_neg;
   logic [SW-1:0]  s_val;
   logic [SW-17:0] ip;
   late_flags_type fb_in;
   late_flags_type fb_ff [0:FB_N-1];

   assign prod_u   = prod_ff;
   assign prod_neg = prod_u[PW-1];
   assign mag      = PW'(0) - prod_u;
   assign s_val    = prod_neg ? SW'((mag + PW'(255)) >> 8) : SW'(prod_u >> 8);
   assign ip       = s_val[SW-1:16];
   assign fb_in.neg = prod_neg && (s_val != '0);
   assign fb_in.big = ip >= (SW - 16)'(PB + 2);

   logic [31:0]    expv_ff  [0:EXP_STEPS];
   logic [15:0]    efrac_ff [0:EXP_STEPS];
   logic [IPW-1:0] eip_ff   [0:EXP_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         expv_ff[0]  <= Q30_ONE;
         efrac_ff[0] <= s_val[15:0];
         eip_ff[0]   <= IPW'(ip);
         fb_ff[0]    <= fb_in;
         for (int i = 1; i < FB_N; i++) begin
            fb_ff[i] <= fb_ff[i-1];
         end
      end
   end

   // One exp2 stage per fraction bit, most significant first.
   for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_exp
      localparam logic [31:0] COEF = exp2_coef(k);
      logic [63:0] mult;
      assign mult = 64'(expv_ff[k-1]) * 64'(COEF);
      always_ff @(posedge clock) begin
         if (en) begin
            expv_ff[k]  <= efrac_ff[k-1][EXP_STEPS-k] ? 32'(mult >> 30) : expv_ff[k-1];
            efrac_ff[k] <= efrac_ff[k-1];
            eip_ff[k]   <= eip_ff[k-1];
         end
      end
   end

   // Denominator 1 + 2^t in Q30, then the rounded reciprocal.
   logic [DW-1:0] den_ff;
   logic [PB:0]   quo;

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= DW'(Q30_ONE) + (DW'(expv_ff[EXP_STEPS]) << eip_ff[EXP_STEPS]);
      end
   end

   s1cp_recip #(.PB(PB)) u_recip (
      .clock(clock), .enable(en), .den(den_ff), .quo(quo)
   );

   // Special cases resolve here: zero distance gives one, a zero product gives zero, and a
   // large exponent drives the quotient to zero before the sign is applied.
   logic [PB:0]     prob_in;
   logic [PB:0]     q_eff;
   early_flags_type fa_end;
   late_flags_type  fb_end;

   assign fa_end = fa_ff[FA_N-1];
   assign fb_end = fb_ff[FB_N-1];
   assign q_eff  = fb_end.big ? '0 : quo;

   always_comb begin
      if (fa_end.dist_zero) begin
         prob_in = PROB_ONE;
      end else if (fa_end.prod_zero) begin
         prob_in = '0;
      end else if (fb_end.neg) begin
         prob_in = PROB_ONE - q_eff;
      end else begin
         prob_in = q_eff;
      end
   end

   // Output register with one skid entry behind it.
   logic [PB:0] out_data_ff;
   logic [PB:0] skid_data_ff;
   logic        push;
   logic        pop;

   assign push = en && vld_ff[P_END];
   assign pop  = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= prob_in;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= prob_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_link_probability = out_data_ff;

   // The skid entry is only ever filled behind a waiting output.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a beat while the output register is empty");

   // A finished beat at the pipeline end must not move while the skid entry is full.
   a_hold_on_full: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && vld_ff[P_END]) |=> vld_ff[P_END])
      else $error("pipeline end beat lost while stalled");

   // Taking the output drains the skid entry at once.
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> !skid_valid_ff)
      else $error("skid entry not drained after the output was taken");

   // A probability never exceeds one.
   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_link_probability <= PROB_ONE))
      else $error("link probability above one");

endmodule
